[design/frp_pkg.sv]
`default_nettype none
package frp_pkg;

    // reply kinds passed from the parser to the emitter
    typedef logic reply_kind_t;
    localparam reply_kind_t REPLY_INFO  = 1'b0;
    localparam reply_kind_t REPLY_CHUNK = 1'b1;

    // reply byte index, wide enough to reach the trailing sum byte
    localparam int IDX_W = 5;
    typedef logic [IDX_W-1:0] reply_idx_t;

    localparam int BODY_DEPTH = 16;
    localparam reply_idx_t INFO_LEN  = 5'd16;
    localparam reply_idx_t CHUNK_LEN = 5'd13;

    // depth of the command queue between parser and emitter (power of two)
    localparam int QUEUE_DEPTH = 2;

    // frame field sizes, defaults for the top-level parameters
    localparam int LENGTH_BYTES_DEF    = 2;
    localparam int OFFSET_BYTES_DEF    = 4;
    localparam int FILE_SIZE_BYTES_DEF = 4;

    // reply bodies, the trailing checksum byte is built by the emitter
    localparam logic [7:0] INFO_BODY [BODY_DEPTH] = '{
        8'h01, 8'h34, 8'h12, 8'h02, 8'h02, 8'h02, 8'h02, 8'h08,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h2E, 8'h6A, 8'h70, 8'h67
    };

    // chunk body padded with zeros to the common depth
    localparam logic [7:0] CHUNK_BODY [BODY_DEPTH] = '{
        8'h03, 8'h01, 8'h00, 8'h09, 8'h08, 8'h08, 8'h07, 8'h06,
        8'h05, 8'h04, 8'h03, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00
    };

    // number of body bytes ahead of the sum byte
    function automatic reply_idx_t reply_len(input reply_kind_t kind);
        reply_idx_t len;
        len = (kind == REPLY_CHUNK) ? CHUNK_LEN : INFO_LEN;
        return len;
    endfunction

    // body byte at a given index
    function automatic logic [7:0] reply_body(input reply_kind_t kind, input reply_idx_t idx);
        logic [7:0] b;
        b = (kind == REPLY_CHUNK) ? CHUNK_BODY[idx[3:0]] : INFO_BODY[idx[3:0]];
        return b;
    endfunction

endpackage
`default_nettype wire

[design/frp_parser.sv]
`default_nettype none
module frp_parser #(
    parameter int LENGTH_BYTES    = frp_pkg::LENGTH_BYTES_DEF,
    parameter int OFFSET_BYTES    = frp_pkg::OFFSET_BYTES_DEF,
    parameter int FILE_SIZE_BYTES = frp_pkg::FILE_SIZE_BYTES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                byte_valid,
    input  wire logic [7:0]          byte_data,
    output logic                     push,
    output frp_pkg::reply_kind_t     push_kind
);

    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_LEN   = 4'd1;
    localparam logic [3:0] PH_FMT   = 4'd2;
    localparam logic [3:0] PH_CSUM  = 4'd3;
    localparam logic [3:0] PH_OFS   = 4'd4;
    localparam logic [3:0] PH_FSIZE = 4'd5;
    localparam logic [3:0] PH_NSIZE = 4'd6;
    localparam logic [3:0] PH_NAME  = 4'd7;
    localparam logic [3:0] PH_CHK   = 4'd8;

    localparam logic [7:0] TYPE_INFO  = 8'h00;
    localparam logic [7:0] TYPE_CHUNK = 8'h02;

    logic [3:0] phase_reg, phase_next;
    logic       chunk_reg, chunk_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] nsize_reg, nsize_next;
    logic [8:0] count_inc;
    logic       len_done, ofs_done, fsize_done, name_done;

    // byte counter compare for each multi-byte part
    assign count_inc  = {1'b0, count_reg} + 9'd1;
    assign len_done   = count_inc >= 9'(LENGTH_BYTES);
    assign ofs_done   = count_inc >= 9'(OFFSET_BYTES);
    assign fsize_done = count_inc >= 9'(FILE_SIZE_BYTES);
    assign name_done  = count_inc >= {1'b0, nsize_reg};

    // frame parse state machine
    always_comb begin
        phase_next = phase_reg;
        chunk_next = chunk_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        nsize_next = nsize_reg;
        push       = 1'b0;
        push_kind  = frp_pkg::REPLY_INFO;
        if (byte_valid) begin
            unique case (phase_reg)
                PH_LEN: begin
                    sum_next = sum_reg + byte_data;
                    if (len_done) begin
                        count_next = '0;
                        phase_next = chunk_reg ? PH_OFS : PH_FMT;
                    end else begin
                        count_next = count_inc[7:0];
                    end
                end
                PH_FMT: begin
                    sum_next   = sum_reg + byte_data;
                    phase_next = PH_CSUM;
                end
                PH_CSUM: begin
                    push       = (sum_reg == byte_data);
                    push_kind  = frp_pkg::REPLY_INFO;
                    phase_next = PH_HUNT;
                end
                PH_OFS: begin
                    if (ofs_done) begin
                        count_next = '0;
                        phase_next = PH_FSIZE;
                    end else begin
                        count_next = count_inc[7:0];
                    end
                end
                PH_FSIZE: begin
                    if (fsize_done) begin
                        count_next = '0;
                        phase_next = PH_NSIZE;
                    end else begin
                        count_next = count_inc[7:0];
                    end
                end
                PH_NSIZE: begin
                    nsize_next = byte_data;
                    count_next = '0;
                    phase_next = PH_NAME;
                end
                PH_NAME: begin
                    if (name_done) begin
                        count_next = '0;
                        phase_next = PH_CHK;
                    end else begin
                        count_next = count_inc[7:0];
                    end
                end
                PH_CHK: begin
                    push       = 1'b1;
                    push_kind  = frp_pkg::REPLY_CHUNK;
                    chunk_next = 1'b0;
                    phase_next = PH_HUNT;
                end
                default: begin
                    if (byte_data == TYPE_INFO || byte_data == TYPE_CHUNK) begin
                        chunk_next = (byte_data == TYPE_CHUNK);
                        count_next = '0;
                        sum_next   = '0;
                        phase_next = PH_LEN;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            chunk_reg <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
            nsize_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            nsize_reg <= nsize_next;
        end
    end

    // only chunk frames walk through the offset and name phases
    a_chunk_phases: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_OFS || phase_reg == PH_NAME) |-> chunk_reg)
        else $error("chunk phase reached outside a chunk frame");

endmodule
`default_nettype wire

[design/frp_queue.sv]
`default_nettype none
module frp_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire frp_pkg::reply_kind_t push_kind,
    output logic                     not_full,
    input  wire logic                pop,
    output logic                     not_empty,
    output frp_pkg::reply_kind_t     head_kind
);

    localparam int DEPTH = frp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frp_pkg::reply_kind_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_full  = count_reg != CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head_kind = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_kind;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("command queue underflow");

endmodule
`default_nettype wire

[design/frp_emitter.sv]
`default_nettype none
module frp_emitter (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cmd_valid,
    input  wire frp_pkg::reply_kind_t cmd_kind,
    output logic                     cmd_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,
    output logic                     m_tlast
);

    logic                 active_reg;
    frp_pkg::reply_kind_t kind_reg;
    frp_pkg::reply_idx_t  idx_reg;
    logic [7:0]           sum_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_data_reg;
    logic                 out_last_reg;
    logic                 advance;
    logic                 at_sum;
    logic [7:0]           body_byte;

    // output register free or being taken this cycle
    assign advance   = !out_valid_reg || m_tready;
    assign at_sum    = idx_reg == frp_pkg::reply_len(kind_reg);
    assign body_byte = frp_pkg::reply_body(kind_reg, idx_reg);
    assign cmd_pop   = !active_reg && cmd_valid;

    // reply sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            sum_reg    <= '0;
        end else if (cmd_pop) begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
            sum_reg    <= '0;
        end else if (active_reg && advance) begin
            sum_reg <= sum_reg + body_byte;
            idx_reg <= idx_reg + frp_pkg::IDX_W'(1);
            if (at_sum) begin
                active_reg <= 1'b0;
            end
        end
    end

    // reply kind of the run in progress
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            kind_reg <= cmd_kind;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && active_reg) begin
            out_data_reg <= at_sum ? sum_reg : body_byte;
            out_last_reg <= at_sum;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> idx_reg <= frp_pkg::reply_len(kind_reg))
        else $error("reply index past the sum byte");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && advance && at_sum) |=> (!active_reg && m_tvalid && m_tlast))
        else $error("reply run did not end on the sum byte");

endmodule
`default_nettype wire

[design/frame_request_parser_responder.sv]
// frame request parser and responder
//
// s_ channel: one received serial byte per item in s_tdata. the parser
// hunts for a type byte (0x00 info, 0x02 chunk), walks the frame and, on a
// valid info frame or any complete chunk frame, queues a reply command.
// m_ channel: reply bytes, one per item, m_tlast high on the closing sum
// byte. info replies are 17 items, chunk replies 14.
// s_tready is high whenever the two-entry command queue has room, so bytes
// are taken back to back, one per cycle, while replies are still going out.
// the first reply byte is offered once the closing item has passed the
// command queue and the reply sequencer; reply bytes then leave at one per
// cycle while m_tready is high, from the single emitter output register.
// a stalled m_ side holds the current byte; the parser keeps taking bytes
// until two further replies are waiting, then drops s_tready.
// reset (aresetn low, synchronous) returns the parser to hunting, empties
// the queue and clears the output register.
`default_nettype none
module frame_request_parser_responder #(
    parameter int LENGTH_BYTES    = frp_pkg::LENGTH_BYTES_DEF,
    parameter int OFFSET_BYTES    = frp_pkg::OFFSET_BYTES_DEF,
    parameter int FILE_SIZE_BYTES = frp_pkg::FILE_SIZE_BYTES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] tx_byte
    output logic            m_tlast
);

    logic                 in_take;
    logic                 push;
    frp_pkg::reply_kind_t push_kind;
    logic                 q_not_full;
    logic                 q_not_empty;
    frp_pkg::reply_kind_t head_kind;
    logic                 pop;

    assign s_tready = q_not_full;
    assign in_take  = s_tvalid && s_tready;

    // front: frame parser
    frp_parser #(
        .LENGTH_BYTES   (LENGTH_BYTES),
        .OFFSET_BYTES   (OFFSET_BYTES),
        .FILE_SIZE_BYTES(FILE_SIZE_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_valid(in_take),
        .byte_data (s_tdata),
        .push      (push),
        .push_kind (push_kind)
    );

    // command queue
    frp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_kind(push_kind),
        .not_full (q_not_full),
        .pop      (pop),
        .not_empty(q_not_empty),
        .head_kind(head_kind)
    );

    // back: reply emitter
    frp_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(q_not_empty),
        .cmd_kind (head_kind),
        .cmd_pop  (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

[bench/frp_codes_pkg.sv]
// frame type bytes shared by the stimulus and the checker
package frp_codes_pkg;

    localparam logic [7:0] TYPE_INFO  = 8'h00;
    localparam logic [7:0] TYPE_CHUNK = 8'h02;

endpackage

[bench/frp_checker.sv]
// watches both channels, predicts reply items and compares them in order
module frp_checker #(
    parameter int LENGTH_BYTES    = frp_pkg::LENGTH_BYTES_DEF,
    parameter int OFFSET_BYTES    = frp_pkg::OFFSET_BYTES_DEF,
    parameter int FILE_SIZE_BYTES = frp_pkg::FILE_SIZE_BYTES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,   // [7:0] tx_byte
    input  wire logic       m_tlast,
    output int              err_count,
    output int              pending,
    output int              beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        ST_HUNT, ST_LEN, ST_FMT, ST_CSUM, ST_OFS, ST_FSIZE, ST_NSIZE, ST_NAME, ST_CHK
    } parse_state_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } reply_beat_t;

    // reply bodies, first byte in the lowest bits
    localparam logic [16*8-1:0] INFO_REPLY = {
        8'h67, 8'h70, 8'h6A, 8'h2E, 8'h34, 8'h33, 8'h32, 8'h31,
        8'h08, 8'h02, 8'h02, 8'h02, 8'h02, 8'h12, 8'h34, 8'h01
    };
    localparam logic [13*8-1:0] CHUNK_REPLY = {
        8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h08, 8'h09, 8'h00, 8'h01, 8'h03
    };
    localparam int INFO_REPLY_LEN  = 16;
    localparam int CHUNK_REPLY_LEN = 13;

    parse_state_t st;
    logic         is_chunk;
    logic [7:0]   part_cnt;
    logic [7:0]   len_fmt_sum;
    logic [7:0]   name_len;
    reply_beat_t  reply_bytes_q[$];

    // count one byte of a multi-byte field, true once the field is complete
    function automatic bit part_done(input int need);
        int n;
        n = part_cnt + 1;
        if (n >= need) begin
            part_cnt = 8'd0;
            return 1'b1;
        end
        part_cnt = n[7:0];
        return 1'b0;
    endfunction

    // queue a fixed reply body plus its closing sum byte
    task automatic queue_reply(input logic [16*8-1:0] body, input int len);
        logic [7:0]  sum;
        reply_beat_t beat;
        sum = 8'd0;
        for (int k = 0; k < len; k++) begin
            beat.tx_byte = body[k*8 +: 8];
            beat.last    = 1'b0;
            sum          = sum + beat.tx_byte;
            reply_bytes_q.push_back(beat);
        end
        beat.tx_byte = sum;
        beat.last    = 1'b1;
        reply_bytes_q.push_back(beat);
    endtask

    // frame parser, one received byte per call
    task automatic parse_rx_byte(input logic [7:0] b);
        case (st)
            ST_LEN: begin
                len_fmt_sum = len_fmt_sum + b;
                if (part_done(LENGTH_BYTES)) st = is_chunk ? ST_OFS : ST_FMT;
            end
            ST_FMT: begin
                len_fmt_sum = len_fmt_sum + b;
                st = ST_CSUM;
            end
            ST_CSUM: begin
                // a bad checksum drops the request silently
                if (len_fmt_sum == b) queue_reply(INFO_REPLY, INFO_REPLY_LEN);
                st = ST_HUNT;
            end
            ST_OFS: begin
                if (part_done(OFFSET_BYTES)) st = ST_FSIZE;
            end
            ST_FSIZE: begin
                if (part_done(FILE_SIZE_BYTES)) st = ST_NSIZE;
            end
            ST_NSIZE: begin
                name_len = b;
                part_cnt = 8'd0;
                st = ST_NAME;
            end
            ST_NAME: begin
                // a zero name size still eats one byte
                if (part_done(int'(name_len))) st = ST_CHK;
            end
            ST_CHK: begin
                // chunk checksum is taken as is
                queue_reply(128'(CHUNK_REPLY), CHUNK_REPLY_LEN);
                is_chunk = 1'b0;
                st = ST_HUNT;
            end
            default: begin
                if (b == frp_codes_pkg::TYPE_INFO || b == frp_codes_pkg::TYPE_CHUNK) begin
                    is_chunk    = (b == frp_codes_pkg::TYPE_CHUNK);
                    part_cnt    = 8'd0;
                    len_fmt_sum = 8'd0;
                    st = ST_LEN;
                end else begin
                    st = ST_HUNT;
                end
            end
        endcase
    endtask

    // compare reply items first, then feed the accepted byte to the parser
    always @(posedge aclk) begin : monitor
        reply_beat_t want;
        if (!aresetn) begin
            st            = ST_HUNT;
            is_chunk      = 1'b0;
            part_cnt      = 8'd0;
            len_fmt_sum   = 8'd0;
            name_len      = 8'd0;
            err_count     = 0;
            beats_checked = 0;
            reply_bytes_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_bytes_q.size() == 0) begin
                    $error("unexpected reply item: tx_byte %h last %b", m_tdata, m_tlast);
                    err_count++;
                end else begin
                    want = reply_bytes_q.pop_front();
                    beats_checked++;
                    if (m_tdata !== want.tx_byte) begin
                        $error("tx_byte: expected %h, actual %h", want.tx_byte, m_tdata);
                        err_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, m_tlast);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
        end
        pending = reply_bytes_q.size();
    end

endmodule

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 15;
    localparam int DRAIN_CYCLES = 20;
    localparam int CHUNK_HEAD   = frp_pkg::LENGTH_BYTES_DEF + frp_pkg::OFFSET_BYTES_DEF
                                + frp_pkg::FILE_SIZE_BYTES_DEF;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit hold_req     = 1'b0;
    int items_sent   = 0;
    int frames_sent  = 0;
    int cycle_cnt    = 0;
    int err_count;
    int pending;
    int beats_checked;

    always #5 aclk = ~aclk;

    frame_request_parser_responder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    frp_checker u_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .err_count     (err_count),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    // reply side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offer one received byte, called and returning at a falling edge
    task automatic send_item(input logic [7:0] b);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // info request, csum_err of zero gives a matching checksum
    task automatic send_info(input logic [15:0] len, input logic [7:0] fmt,
                             input logic [7:0] csum_err);
        logic [7:0] csum;
        csum = len[7:0] + len[15:8] + fmt + csum_err;
        send_item(frp_codes_pkg::TYPE_INFO);
        send_item(len[7:0]);
        send_item(len[15:8]);
        send_item(fmt);
        send_item(csum);
        frames_sent++;
    endtask

    // chunk request, fields random or all set to one fill byte
    task automatic send_chunk(input logic [7:0] nsize, input bit rand_body,
                              input logic [7:0] fill);
        logic [7:0] v;
        int         name_bytes;
        name_bytes = (nsize == 8'd0) ? 1 : int'(nsize);
        send_item(frp_codes_pkg::TYPE_CHUNK);
        repeat (CHUNK_HEAD) begin
            v = rand_body ? 8'($urandom) : fill;
            send_item(v);
        end
        send_item(nsize);
        repeat (name_bytes) begin
            v = rand_body ? 8'($urandom) : fill;
            send_item(v);
        end
        v = rand_body ? 8'($urandom) : fill;
        send_item(v);
        frames_sent++;
    endtask

    // mostly well-formed frames, some noise and cut-off frames
    task automatic send_random_frame();
        int         pick;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_info(16'($urandom), 8'($urandom), 8'd0);
        end else if (pick < 45) begin
            send_info(16'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
        end else if (pick < 80) begin
            v = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 20))
                                            : 8'($urandom_range(0, 3));
            send_chunk(v, 1'b1, 8'd0);
        end else if (pick < 90) begin
            v = 8'($urandom);
            while (v == frp_codes_pkg::TYPE_INFO || v == frp_codes_pkg::TYPE_CHUNK) begin
                v = 8'($urandom);
            end
            send_item(v);
        end else begin
            // frame cut short, the following bytes run into it
            send_item(($urandom_range(0, 1) != 0) ? frp_codes_pkg::TYPE_CHUNK
                                                  : frp_codes_pkg::TYPE_INFO);
            repeat ($urandom_range(1, 5)) begin
                v = 8'($urandom);
                send_item(v);
            end
        end
    endtask

    task automatic random_phase();
        int start;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) send_random_frame();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sender idles less than receiver
        snd_idle_pct = 20;
        rcv_idle_pct = 69;
        // directed: junk byte, extreme info frame, bad checksum, zero name size
        send_item(8'hFF);
        send_info(16'hFFFF, 8'hFF, 8'd0);
        send_info(16'h0000, 8'h00, 8'd1);
        send_chunk(8'd0, 1'b0, 8'h00);
        random_phase();

        // receiver idles less than sender
        snd_idle_pct = 69;
        rcv_idle_pct = 20;
        random_phase();

        // no idling, long output hold-off while requests keep coming
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (5) send_info(16'($urandom), 8'($urandom), 8'd0);
        random_phase();
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d input items, %0d frames, %0d reply items checked",
                 items_sent, frames_sent, beats_checked);
        $display("run: idle mixes 20/69, 69/20 and none, one long reply hold-off");
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
